@@ hw/rtl/mtwc_pkg.sv @@
// Shared types and constants for the median time window check block.
// No dependencies; every other file in hw/rtl takes its names from here.
`default_nettype none

package mtwc_pkg;

  localparam int TIME_W   = 32;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TOO_OLD = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TOO_NEW = 2'd2;

  localparam logic ACTION_APPEND = 1'b0;
  localparam logic ACTION_CHECK  = 1'b1;

  localparam logic [31:0] DRIFT_RESET = 32'd7200;

  typedef struct packed {
    logic clear;
    logic insert;
  } sort_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/mtwc_store.sv @@
// Timestamp store: one write port and one read port with registered read data.
// Uses mtwc_pkg for the timestamp width.
`default_nettype none

module mtwc_store #(
  parameter int WINDOW = 11,
  parameter int AW     = 4
) (
  input  wire                        clk,
  input  wire                        we,
  input  wire [AW-1:0]               waddr,
  input  wire [mtwc_pkg::TIME_W-1:0] wdata,
  input  wire                        re,
  input  wire [AW-1:0]               raddr,
  output logic [mtwc_pkg::TIME_W-1:0] rdata
);

  logic [mtwc_pkg::TIME_W-1:0] mem [WINDOW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mtwc_sorter.sv @@
// Insertion sorter: a row of registers kept in ascending order, one value per beat.
// Uses mtwc_pkg for the timestamp width and the control struct.
`default_nettype none

module mtwc_sorter #(
  parameter int WINDOW = 11,
  parameter int AW     = 4,
  parameter int CW     = 4
) (
  input  wire                          clk,
  input  wire                          rst,
  input  mtwc_pkg::sort_ctrl_t         ctrl,
  input  wire [mtwc_pkg::TIME_W-1:0]   value,
  input  wire [AW-1:0]                 sel,
  output logic [mtwc_pkg::TIME_W-1:0]  sel_value
);

  logic [mtwc_pkg::TIME_W-1:0] row      [WINDOW];
  logic [mtwc_pkg::TIME_W-1:0] row_next [WINDOW];
  logic [WINDOW-1:0]           below;
  logic [CW-1:0]               used;

  always_comb begin
    for (int k = 0; k < WINDOW; k++) begin
      below[k] = (CW'(k) < used) && (row[k] <= value);
    end
    row_next[0] = below[0] ? row[0] : value;
    for (int k = 1; k < WINDOW; k++) begin
      if (below[k]) begin
        row_next[k] = row[k];
      end else if (below[k-1]) begin
        row_next[k] = value;
      end else begin
        row_next[k] = row[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (ctrl.clear) begin
      used <= '0;
    end else if (ctrl.insert && used < CW'(WINDOW)) begin
      used <= used + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      for (int k = 0; k < WINDOW; k++) begin
        row[k] <= row_next[k];
      end
    end
  end

  assign sel_value = row[sel];

endmodule

`default_nettype wire

@@ hw/rtl/median_time_window_check_core.sv @@
// Median time window check: an accepted beat passes through ST_SCAN, which reads the n
// stored timestamps (n counted after the beat), then ST_WAIT and ST_RESULT; with an
// empty window it goes straight to ST_RESULT. No new beat is taken until ST_IDLE.
// The scan is set by the single read port of the store, one entry per cycle.
// Reset empties the window and sets the drift limit to 7200; store contents stay.
`default_nettype none

module median_time_window_check_core #(
  parameter int WINDOW = 11
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [63:0] s_tdata,  // block_time [31:0], current_time [63:32]
  input  wire  [0:0]  s_tuser,  // action
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [39:0] m_tdata,  // median_time [31:0], status [33:32], zeros above
  input  wire         cfg_we,
  input  wire  [31:0] cfg_wdata
);

  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);
  localparam int TW = mtwc_pkg::TIME_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_RESULT
  } state_t;

  state_t               state;
  logic [CW-1:0]        fill_count;
  logic [AW-1:0]        write_slot;
  logic [AW-1:0]        rd_idx;
  logic                 rd_vld;
  logic                 action;
  logic [TW-1:0]        cand_time;
  logic [TW:0]          limit;
  logic [TW-1:0]        drift;
  logic [TW-1:0]        rd_data;
  logic [TW-1:0]        sel_value;
  logic [TW-1:0]        median;
  logic [mtwc_pkg::STATUS_W-1:0] status;
  logic                 accept;
  logic                 do_append;
  logic [CW-1:0]        fill_next;
  logic [AW-1:0]        last_idx;
  logic                 out_free;
  mtwc_pkg::sort_ctrl_t sort_ctrl;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign do_append = accept && (s_tuser[0] == mtwc_pkg::ACTION_APPEND);
  assign fill_next = (do_append && fill_count < CW'(WINDOW)) ? fill_count + 1'b1
                                                           : fill_count;
  assign last_idx  = AW'(fill_count - 1'b1);
  assign out_free  = !m_tvalid || m_tready;

  assign sort_ctrl.clear  = accept;
  assign sort_ctrl.insert = rd_vld;

  mtwc_store #(
    .WINDOW (WINDOW),
    .AW     (AW)
  ) u_store (
    .clk   (clk),
    .we    (do_append),
    .waddr (write_slot),
    .wdata (s_tdata[31:0]),
    .re    (state == ST_SCAN),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  mtwc_sorter #(
    .WINDOW (WINDOW),
    .AW     (AW),
    .CW     (CW)
  ) u_sorter (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (sort_ctrl),
    .value     (rd_data),
    .sel       (AW'(fill_count >> 1)),
    .sel_value (sel_value)
  );

  always_comb begin
    median = (fill_count == '0) ? '0 : sel_value;
    status = mtwc_pkg::STATUS_OK;
    if (action == mtwc_pkg::ACTION_CHECK) begin
      if (cand_time < median) begin
        status = mtwc_pkg::STATUS_TOO_OLD;
      end else if ({1'b0, cand_time} > limit) begin
        status = mtwc_pkg::STATUS_TOO_NEW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drift <= mtwc_pkg::DRIFT_RESET;
    end else if (cfg_we) begin
      drift <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action    <= s_tuser[0];
      cand_time <= s_tdata[31:0];
      limit     <= {1'b0, s_tdata[63:32]} + {1'b0, drift};
    end
    if (state == ST_RESULT && out_free) begin
      m_tdata <= {6'd0, status, median};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_count <= '0;
      write_slot <= '0;
      rd_idx     <= '0;
      rd_vld     <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      rd_vld <= (state == ST_SCAN);
      if (state == ST_RESULT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            fill_count <= fill_next;
            rd_idx     <= '0;
            if (do_append) begin
              write_slot <= (write_slot == AW'(WINDOW - 1)) ? '0 : write_slot + 1'b1;
            end
            state <= (fill_next == '0) ? ST_RESULT : ST_SCAN;
          end
        end
        ST_SCAN: begin
          rd_idx <= rd_idx + 1'b1;
          if (rd_idx == last_idx) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          state <= ST_RESULT;
        end
        ST_RESULT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(WINDOW))
    else $error("fill count exceeds the window depth");

  a_slot_tracks_fill: assert property (@(posedge clk) disable iff (rst)
    (fill_count < CW'(WINDOW)) |-> (CW'(write_slot) == fill_count))
    else $error("write slot diverged from fill count while filling");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (CW'(rd_idx) < fill_count))
    else $error("store read beyond the filled entries");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[33:32] != 2'd3))
    else $error("illegal status code on the result beat");

  a_result_after_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_RESULT))
    else $error("result raised outside the result state");

endmodule

`default_nettype wire
